### src/nrw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NACK retransmit window package
// Shared widths, defaults and codes of the retransmit window block.
// ----------------------------------------------------------------------------
package nrw_pkg;

   localparam int SEQ_W      = 32;
   localparam int DEPTH_DEF  = 64;
   localparam int SLOT_OUT_W = 6;
   localparam int STATUS_W   = 3;
   localparam int FUNC_W     = 2;

   typedef enum logic [FUNC_W-1:0] {
      FN_STORE = 2'd0,
      FN_NACK  = 2'd1,
      FN_EMPTY = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_STORED  = 3'd0,
      ST_REFUSED = 3'd1,
      ST_RESEND  = 3'd2,
      ST_IGNORED = 3'd3,
      ST_ABORTED = 3'd4,
      ST_UPDATED = 3'd5
   } status_type;

endpackage

### src/nrw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nrw_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = nrw_pkg::DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/nrw_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NACK retransmit window slot number unit
// Reduces a sequence number modulo DEPTH by reciprocal multiplication: a
// registered 32 by 32 bit product, then one correcting subtraction.
// ----------------------------------------------------------------------------
module nrw_mod #(
   parameter int DEPTH = nrw_pkg::DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [nrw_pkg::SEQ_W-1:0] dividend,
   output logic                      done,
   output logic [$clog2(DEPTH)-1:0]  remainder
);

   localparam int SW    = nrw_pkg::SEQ_W;
   localparam int AW    = $clog2(DEPTH);
   // Floor of log2(DEPTH); it keeps the reciprocal within SW bits.
   localparam int LG    = $clog2(DEPTH + 1) - 1;
   localparam int SHIFT = SW - 1 + LG;
   localparam logic [63:0]   RECIP_W = (64'd1 << SHIFT) / 64'(DEPTH);
   localparam logic [SW-1:0] RECIP   = RECIP_W[SW-1:0];
   localparam logic [AW:0]   DEPTH_R = (AW + 1)'(DEPTH);

   logic            load_ff, load_in;
   logic            mult_ff, mult_in;
   logic            done_ff, done_in;
   logic [SW-1:0]   x_ff, x_in;
   logic [63:0]     prod_ff, prod_in;
   logic [AW-1:0]   rem_ff, rem_in;
   logic [AW:0]     q_lo;
   logic [AW:0]     qd;
   logic [AW:0]     r_raw;

   // The estimated quotient is the true one or one less, so the remainder
   // estimate lies below 2*DEPTH and only its low AW+1 bits are needed.
   always_comb begin
      load_in = start;
      mult_in = load_ff;
      done_in = mult_ff;
      x_in    = start ? dividend : x_ff;
      prod_in = 64'(x_ff) * 64'(RECIP);
      q_lo    = prod_ff[SHIFT +: AW + 1];
      qd      = q_lo * DEPTH_R;
      r_raw   = x_ff[AW:0] - qd;
      rem_in  = (r_raw >= DEPTH_R) ? AW'(r_raw - DEPTH_R) : r_raw[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b0;
         mult_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         load_ff <= load_in;
         mult_ff <= mult_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### src/nack_retransmit_window_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NACK retransmit window
// Tracks slot occupancy of a sender's retransmit window and answers store,
// NACK word and empty NACK requests with one response each.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                   tuser               tlast
//  req_     in   seq_num, link_valid                     func, first_word    last_word
//  rsp_     out  slot_index, seq_out, can_buffer,        status              -
//                resent_total, window_start
//
//  From acceptance a request passes the slot number unit, one slot memory
//  read, one evaluation and one load of the response. A closing NACK word
//  that releases n slots (n <= DEPTH) adds a pass that reads each of them and
//  writes it back empty, bound by the one read and one write port of the slot
//  memory. After reset a clearing pass writes every slot empty; req_tready
//  stays low meanwhile. A response waiting on rsp_tready does not stop the next
//  request being accepted and worked on; its response then waits to be loaded.
// ----------------------------------------------------------------------------
module nack_retransmit_window_unit #(
   parameter int DEPTH = nrw_pkg::DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // seq_num[31:0], link_valid[32], zero pad
   input  logic [2:0]   req_tuser,   // func[1:0], first_word[2]
   input  logic         req_tlast,   // last_word
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // slot_index[5:0], seq_out[37:6], can_buffer[38], resent_total[70:39],
   // window_start[102:71], zero pad
   output logic [103:0] rsp_tdata,
   output logic [2:0]   rsp_tuser    // status
);

   localparam int SW = nrw_pkg::SEQ_W;
   localparam int AW = $clog2(DEPTH);
   localparam int OW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_MOD,
      S_EVAL,
      S_SWEEP,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [AW-1:0]         init_addr_ff, init_addr_in;
   nrw_pkg::func_type     func_ff, func_in;
   logic [SW-1:0]         seq_ff, seq_in;
   logic                  first_ff, first_in;
   logic                  last_ff, last_in;
   logic                  link_ff, link_in;
   logic [AW-1:0]         slot_ff, slot_in;
   logic [SW-1:0]         fm_ff, fm_in;
   logic [SW-1:0]         largest_ff, largest_in;
   logic [SW-1:0]         resend_ff, resend_in;
   logic [OW-1:0]         occ_ff, occ_in;
   logic [SW-1:0]         head_ff, head_in;
   logic                  aborted_ff, aborted_in;
   logic [SW-1:0]         ns_ff, ns_in;
   logic [AW-1:0]         sweep_addr_ff, sweep_addr_in;
   logic [AW:0]           sweep_left_ff, sweep_left_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pend_addr_ff, pend_addr_in;
   nrw_pkg::status_type   res_status_ff, res_status_in;
   logic [5:0]            res_slot_ff, res_slot_in;
   logic [SW-1:0]         res_seq_ff, res_seq_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   nrw_pkg::status_type   out_status_ff, out_status_in;
   logic [5:0]            out_slot_ff, out_slot_in;
   logic [SW-1:0]         out_seq_ff, out_seq_in;
   logic                  out_can_ff, out_can_in;
   logic [SW-1:0]         out_resent_ff, out_resent_in;
   logic [SW-1:0]         out_ws_ff, out_ws_in;

   logic                  accept;
   logic                  mod_done;
   logic [AW-1:0]         mod_rem;
   logic [SW-1:0]         mod_dividend;
   nrw_pkg::func_type     req_func;
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic                  ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic                  ram_rdata;
   logic [SW:0]           fm_limit;
   logic [SW-1:0]         new_start;
   logic [SW-1:0]         span;
   logic [SW-1:0]         resend_inc;

   assign req_func   = nrw_pkg::func_type'(req_tuser[1:0]);
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // The slot number wanted depends on the request kind.
   always_comb begin
      if (req_func == nrw_pkg::FN_EMPTY) begin
         mod_dividend = largest_ff;
      end else if (req_func == nrw_pkg::FN_NACK && req_tlast) begin
         mod_dividend = fm_ff;
      end else begin
         mod_dividend = req_tdata[SW-1:0];
      end
   end

   nrw_mod #(
      .DEPTH(DEPTH)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (mod_dividend),
      .done     (mod_done),
      .remainder(mod_rem)
   );

   nrw_ram #(
      .WIDTH(1),
      .DEPTH(DEPTH)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign ram_raddr  = (state_ff == S_SWEEP) ? sweep_addr_ff : mod_rem;
   assign fm_limit   = {1'b0, fm_ff} + (SW + 1)'(DEPTH);
   assign new_start  = first_ff ? head_ff + 1'b1 : head_ff;
   assign span       = new_start - fm_ff;
   assign resend_inc = (resend_ff != '1) ? resend_ff + 1'b1 : resend_ff;

   always_comb begin
      state_in      = state_ff;
      init_addr_in  = init_addr_ff;
      func_in       = func_ff;
      seq_in        = seq_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      link_in       = link_ff;
      slot_in       = slot_ff;
      fm_in         = fm_ff;
      largest_in    = largest_ff;
      resend_in     = resend_ff;
      occ_in        = occ_ff;
      head_in       = head_ff;
      aborted_in    = aborted_ff;
      ns_in         = ns_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_left_in = sweep_left_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_seq_in    = res_seq_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      out_seq_in    = out_seq_ff;
      out_can_in    = out_can_ff;
      out_resent_in = out_resent_ff;
      out_ws_in     = out_ws_ff;
      ram_we        = 1'b0;
      ram_waddr     = slot_ff;
      ram_wdata     = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_INIT: begin
            ram_we       = 1'b1;
            ram_waddr    = init_addr_ff;
            init_addr_in = init_addr_ff + 1'b1;
            if (init_addr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               func_in  = req_func;
               seq_in   = req_tdata[SW-1:0];
               link_in  = req_tdata[SW];
               first_in = req_tuser[2];
               last_in  = req_tlast;
               // A first word opens a new NACK before anything is tested.
               if (req_func == nrw_pkg::FN_NACK && req_tuser[2]) begin
                  head_in    = req_tdata[SW-1:0];
                  aborted_in = 1'b0;
               end
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               slot_in  = mod_rem;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            res_slot_in = 6'(slot_ff);
            res_seq_in  = seq_ff;
            state_in    = S_DONE;
            case (func_ff)
               nrw_pkg::FN_STORE: begin
                  if (occ_ff >= OW'(DEPTH)) begin
                     res_status_in = nrw_pkg::ST_REFUSED;
                  end else begin
                     ram_we    = 1'b1;
                     ram_wdata = 1'b1;
                     if (!ram_rdata) begin
                        occ_in = occ_ff + 1'b1;
                     end
                     if (seq_ff > largest_ff) begin
                        largest_in = seq_ff;
                     end
                     res_status_in = nrw_pkg::ST_STORED;
                  end
               end
               nrw_pkg::FN_NACK: begin
                  if (!last_ff) begin
                     if (aborted_ff) begin
                        res_status_in = nrw_pkg::ST_ABORTED;
                     end else if (seq_ff < fm_ff) begin
                        res_status_in = nrw_pkg::ST_IGNORED;
                     end else if ({1'b0, seq_ff} >= fm_limit || seq_ff > largest_ff) begin
                        aborted_in    = 1'b1;
                        res_status_in = nrw_pkg::ST_ABORTED;
                     end else if (!ram_rdata) begin
                        res_status_in = nrw_pkg::ST_IGNORED;
                     end else if (!link_ff) begin
                        aborted_in    = 1'b1;
                        res_status_in = nrw_pkg::ST_ABORTED;
                     end else begin
                        resend_in     = resend_inc;
                        res_status_in = nrw_pkg::ST_RESEND;
                     end
                  end else begin
                     aborted_in  = 1'b0;
                     res_slot_in = '0;
                     if (aborted_ff) begin
                        res_status_in = nrw_pkg::ST_ABORTED;
                     end else if (new_start > fm_ff) begin
                        // Release the slots below the new start, one a cycle.
                        ns_in         = new_start;
                        sweep_addr_in = slot_ff;
                        sweep_left_in = (span > SW'(DEPTH)) ? (AW + 1)'(DEPTH)
                                                            : (AW + 1)'(span);
                        state_in      = S_SWEEP;
                     end else begin
                        fm_in         = new_start;
                        res_status_in = nrw_pkg::ST_UPDATED;
                        res_seq_in    = new_start;
                     end
                  end
               end
               nrw_pkg::FN_EMPTY: begin
                  res_seq_in = largest_ff;
                  if (largest_ff != '0 && ram_rdata && link_ff) begin
                     resend_in     = resend_inc;
                     res_status_in = nrw_pkg::ST_RESEND;
                  end else begin
                     res_status_in = nrw_pkg::ST_IGNORED;
                  end
               end
               default: begin
                  res_status_in = nrw_pkg::ST_IGNORED;
                  res_slot_in   = '0;
                  res_seq_in    = '0;
               end
            endcase
         end
         S_SWEEP: begin
            // The slot read in the previous cycle is written back empty now.
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pend_addr_ff;
               ram_wdata = 1'b0;
               if (ram_rdata && occ_ff != '0) begin
                  occ_in = occ_ff - 1'b1;
               end
            end
            if (sweep_left_ff != '0) begin
               pend_in       = 1'b1;
               pend_addr_in  = sweep_addr_ff;
               sweep_addr_in = (sweep_addr_ff == LAST_SLOT) ? '0 : sweep_addr_ff + 1'b1;
               sweep_left_in = sweep_left_ff - 1'b1;
            end else if (!pend_ff) begin
               fm_in         = ns_ff;
               res_status_in = nrw_pkg::ST_UPDATED;
               res_seq_in    = ns_ff;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_slot_in   = res_slot_ff;
               out_seq_in    = res_seq_ff;
               out_can_in    = ({1'b0, largest_ff} + 1'b1) < fm_limit;
               out_resent_in = resend_ff;
               out_ws_in     = fm_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         init_addr_ff  <= '0;
         fm_ff         <= SW'(1);
         largest_ff    <= '0;
         resend_ff     <= '0;
         occ_ff        <= '0;
         head_ff       <= '0;
         aborted_ff    <= 1'b0;
         sweep_left_ff <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_addr_ff  <= init_addr_in;
         fm_ff         <= fm_in;
         largest_ff    <= largest_in;
         resend_ff     <= resend_in;
         occ_ff        <= occ_in;
         head_ff       <= head_in;
         aborted_ff    <= aborted_in;
         sweep_left_ff <= sweep_left_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      func_ff       <= func_in;
      seq_ff        <= seq_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      link_ff       <= link_in;
      slot_ff       <= slot_in;
      ns_ff         <= ns_in;
      sweep_addr_ff <= sweep_addr_in;
      pend_addr_ff  <= pend_addr_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_seq_ff    <= res_seq_in;
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
      out_seq_ff    <= out_seq_in;
      out_can_ff    <= out_can_in;
      out_resent_ff <= out_resent_in;
      out_ws_ff     <= out_ws_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {1'b0, out_ws_ff, out_resent_ff, out_can_ff, out_seq_ff, out_slot_ff};

   // The occupancy count can never exceed the number of slots.
   assert property (@(posedge clock) disable iff (reset) occ_ff <= OW'(DEPTH))
      else $error("slot occupancy count exceeds the window depth");

   // Only one request is worked on at a time.
   assert property (@(posedge clock) disable iff (reset) accept |=> !req_tready)
      else $error("request accepted while another is in progress");

   // The saturating resend count never goes down.
   assert property (@(posedge clock) disable iff (reset) resend_ff >= $past(resend_ff))
      else $error("resend count decreased");

   // Slots are only released for the closing word of a NACK.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |-> (last_ff && func_ff == nrw_pkg::FN_NACK))
      else $error("slot release pass without a closing NACK word");

endmodule
